// ===== design/hsl_pkg.sv =====
`timescale 1ns / 1ps

package hsl_pkg;

  // Fraction bits of saturation and lightness (1 << FRAC_BITS means 1.0).
  localparam int unsigned FRAC_BITS = 12;

  localparam int unsigned IN_W   = 13;
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned QW     = FRAC_BITS + 1;
  // Levels carry 2*FRAC_BITS fraction bits, with headroom for the sums.
  localparam int unsigned LW     = 2 * FRAC_BITS + 2;
  localparam int unsigned FACT_W = 6;
  localparam int unsigned NUM_W  = LW + FACT_W;
  localparam int unsigned SC_W   = NUM_W + 5;
  // 255 / (60 << 2F) equals 17 / (1 << (2F + 2)), so the scaling is exact.
  localparam int unsigned DIV_SH = 2 * FRAC_BITS + 2;

  localparam logic [QW-1:0]    ONE_Q      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
  localparam logic [HUE_W-1:0] HUE_THIRD  = 9'd120;
  localparam logic [HUE_W-1:0] HUE_TWO_TH = 9'd240;
  localparam logic [HUE_W-1:0] DEG_RISE   = 9'd60;
  localparam logic [HUE_W-1:0] DEG_HOLD   = 9'd180;
  localparam logic [HUE_W-1:0] DEG_FALL   = 9'd240;
  localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_RED = 0;
  localparam int unsigned CH_GRN = 1;
  localparam int unsigned CH_BLU = 2;

  typedef logic [HUE_W-1:0] deg_t;
  typedef logic [CH_W-1:0]  chan_t;

  typedef struct packed {
    deg_t [NUM_CH-1:0] deg;
    logic [QW-1:0]     sat;
    logic [QW-1:0]     lig;
    logic              zero;
  } hsl_norm_t;

  typedef struct packed {
    deg_t [NUM_CH-1:0] deg;
    logic [LW-1:0]     hi;
    logic [LW-1:0]     lo;
    logic [LW-1:0]     span;
    chan_t             gray;
    logic              zero;
  } hsl_lvl_t;

endpackage

// ===== design/hsl_norm.sv =====
`timescale 1ns / 1ps

module hsl_norm (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [hsl_pkg::HUE_W-1:0] hue_i,
  input  logic [hsl_pkg::IN_W-1:0]  sat_i,
  input  logic [hsl_pkg::IN_W-1:0]  lig_i,
  output logic                     valid_o,
  output hsl_pkg::hsl_norm_t        data_o
);
  import hsl_pkg::*;

  function automatic deg_t wrap_add(input deg_t a, input deg_t off);
    logic [HUE_W:0] sum;
    sum = {1'b0, a} + {1'b0, off};
    if (sum >= {1'b0, HUE_FULL}) begin
      sum = sum - {1'b0, HUE_FULL};
    end
    return sum[HUE_W-1:0];
  endfunction

  logic      valid_q;
  hsl_norm_t data_d, data_q;
  deg_t      hue_w;

  always_comb begin
    hue_w = (hue_i >= HUE_FULL) ? hue_i - HUE_FULL : hue_i;
    data_d.deg[CH_RED] = wrap_add(hue_w, HUE_THIRD);
    data_d.deg[CH_GRN] = hue_w;
    data_d.deg[CH_BLU] = wrap_add(hue_w, HUE_TWO_TH);
    data_d.sat  = (sat_i > IN_W'(ONE_Q)) ? ONE_Q : QW'(sat_i);
    data_d.lig  = (lig_i > IN_W'(ONE_Q)) ? ONE_Q : QW'(lig_i);
    data_d.zero = (sat_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/hsl_level.sv =====
`timescale 1ns / 1ps

module hsl_level (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hsl_pkg::hsl_norm_t data_i,
  output logic               valid_o,
  output hsl_pkg::hsl_lvl_t  data_o
);
  import hsl_pkg::*;

  // First stage: the product L*S and the gray value.
  logic                valid1_q;
  hsl_norm_t           norm_q;
  logic [2*QW-1:0]     prod_d, prod_q;
  chan_t               gray_d, gray_q;
  logic [QW+CH_W-1:0]  gray_full;

  always_comb begin
    prod_d    = (2*QW)'(data_i.lig) * (2*QW)'(data_i.sat);
    gray_full = ((QW+CH_W)'(data_i.lig) << CH_W) - (QW+CH_W)'(data_i.lig);
    gray_d    = gray_full[FRAC_BITS +: CH_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= data_i;
    prod_q <= prod_d;
    gray_q <= gray_d;
  end

  // Second stage: upper and lower levels and their span.
  logic          valid2_q;
  hsl_lvl_t      lvl_d, lvl_q;
  logic [LW-1:0] lig_s, sat_s, prod_w;

  always_comb begin
    lig_s  = LW'(norm_q.lig) << FRAC_BITS;
    sat_s  = LW'(norm_q.sat) << FRAC_BITS;
    prod_w = LW'(prod_q);
    // Below one half the level is L*(1+S), otherwise L+S-L*S.
    if (!norm_q.lig[FRAC_BITS] && !norm_q.lig[FRAC_BITS-1]) begin
      lvl_d.hi = lig_s + prod_w;
    end else begin
      lvl_d.hi = lig_s + sat_s - prod_w;
    end
    lvl_d.lo   = (lig_s << 1) - lvl_d.hi;
    lvl_d.span = lvl_d.hi - lvl_d.lo;
    lvl_d.deg  = norm_q.deg;
    lvl_d.gray = gray_q;
    lvl_d.zero = norm_q.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign valid_o = valid2_q;
  assign data_o  = lvl_q;

endmodule

// ===== design/hsl_ramp.sv =====
`timescale 1ns / 1ps

module hsl_ramp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  hsl_pkg::hsl_lvl_t                       data_i,
  output logic                                    valid_o,
  output hsl_pkg::chan_t [hsl_pkg::NUM_CH-1:0]    chan_o
);
  import hsl_pkg::*;

  logic                           valid1_q, valid2_q;
  logic [NUM_CH-1:0][LW-1:0]      base_d, base_q;
  logic [NUM_CH-1:0][NUM_W-1:0]   mul_d, mul_q;
  chan_t                          gray_q;
  logic                           zero_q;
  chan_t [NUM_CH-1:0]             chan_d, chan_q;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    deg_t              deg;
    logic [FACT_W-1:0] fact;
    logic [NUM_W-1:0]  num;
    logic [SC_W-1:0]   scaled;
    logic [SC_W-1:0]   quo;

    // Segment choice: rising, holding high, falling, holding low.
    always_comb begin
      deg = data_i.deg[c];
      if (deg < DEG_RISE) begin
        base_d[c] = data_i.lo;
        fact      = deg[FACT_W-1:0];
      end else if (deg < DEG_HOLD) begin
        base_d[c] = data_i.hi;
        fact      = '0;
      end else if (deg < DEG_FALL) begin
        base_d[c] = data_i.lo;
        fact      = FACT_W'(DEG_FALL - deg);
      end else begin
        base_d[c] = data_i.lo;
        fact      = '0;
      end
      mul_d[c] = NUM_W'(data_i.span) * NUM_W'(fact);
    end

    always_comb begin
      num    = (NUM_W'(base_q[c]) << 6) - (NUM_W'(base_q[c]) << 2) + mul_q[c];
      scaled = (SC_W'(num) << 4) + SC_W'(num);
      quo    = scaled >> DIV_SH;
      if (zero_q) begin
        chan_d[c] = gray_q;
      end else if (quo > SC_W'(CH_MAX)) begin
        chan_d[c] = CH_MAX;
      end else begin
        chan_d[c] = quo[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    mul_q  <= mul_d;
    gray_q <= data_i.gray;
    zero_q <= data_i.zero;
    chan_q <= chan_d;
  end

  assign valid_o = valid2_q;
  assign chan_o  = chan_q;

endmodule

// ===== design/hsl_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
// Path: a colour taken with start reaches the result ports with done_o through five
// register stages (input, product, levels, ramp, output).
// Throughput: one colour per clock; busy is never raised, as every stage advances
// each cycle and the receiver always takes the word.
// Reset: rst_ni clears the valid bits of every stage at once; no word is then in flight.

module hsl_to_rgb_converter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [hsl_pkg::HUE_W-1:0] hue_degrees_i,
  input  logic [hsl_pkg::IN_W-1:0]  saturation_i,
  input  logic [hsl_pkg::IN_W-1:0]  lightness_i,
  output logic                      done_o,
  output logic [hsl_pkg::CH_W-1:0]  red_o,
  output logic [hsl_pkg::CH_W-1:0]  green_o,
  output logic [hsl_pkg::CH_W-1:0]  blue_o
);
  import hsl_pkg::*;

  logic               norm_valid, lvl_valid, out_valid;
  hsl_norm_t          norm_data;
  hsl_lvl_t           lvl_data;
  chan_t [NUM_CH-1:0] chan;

  assign busy = 1'b0;

  hsl_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .hue_i   (hue_degrees_i),
    .sat_i   (saturation_i),
    .lig_i   (lightness_i),
    .valid_o (norm_valid),
    .data_o  (norm_data)
  );

  hsl_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .data_i  (norm_data),
    .valid_o (lvl_valid),
    .data_o  (lvl_data)
  );

  hsl_ramp u_ramp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lvl_valid),
    .data_i  (lvl_data),
    .valid_o (out_valid),
    .chan_o  (chan)
  );

  assign done_o  = out_valid;
  assign red_o   = chan[CH_RED];
  assign green_o = chan[CH_GRN];
  assign blue_o  = chan[CH_BLU];

  // Every accepted word comes out with done_o, and no result word appears without one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##5 done_o)
    else $error("accepted word did not emerge after five cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 5))
    else $error("result word without a matching accepted word");

  // Zero saturation must give a gray result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(saturation_i == '0, 5) |-> red_o == green_o && green_o == blue_o)
    else $error("zero saturation did not give gray");

  // Full lightness must give white, whatever the hue and saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(lightness_i >= IN_W'(ONE_Q), 5)
      |-> red_o == CH_MAX && green_o == CH_MAX && blue_o == CH_MAX)
    else $error("full lightness did not give white");

  // Zero lightness must give black.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(lightness_i == '0, 5)
      |-> red_o == '0 && green_o == '0 && blue_o == '0)
    else $error("zero lightness did not give black");

endmodule
